// ===== src/brkg_pkg.sv =====
// Shared types and constants for the group reversal block.
package brkg_pkg;

    localparam int MAX_GROUP_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int VALUE_W       = 32;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(1);

    // Per-command flags passed from the front to the back through the queue.
    typedef struct packed {
        logic bank;
        logic rev;
        logic seq_end;
    } cmd_flags_t;

    localparam int FLAGS_W = $bits(cmd_flags_t);

    // Back tells the front that a bank has been fully read out.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

// ===== src/brkg_ram.sv =====
// Two-bank group store: one write port, one read port with registered read data.
module brkg_ram
    import brkg_pkg::*;
#(
    parameter int ADDR_W = 5
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [VALUE_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read register holds while no read is issued, so it doubles as output register
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/brkg_cmdq.sv =====
// Two-entry command queue between the front and the back.
module brkg_cmdq
    import brkg_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wptr_reg;
    logic              wptr_next;
    logic              rptr_reg;
    logic              rptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rptr_reg];

endmodule

// ===== src/brkg_front.sv =====
// Front end: takes input words, fills the current bank, issues drain commands.
module brkg_front
    import brkg_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF,
    parameter int CNT_W     = $clog2(MAX_GROUP + 1),
    parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // value
    input  logic               s_tlast,    // seq_end
    input  bank_rel_t          rel,
    input  logic               q_full,
    output logic               q_push,
    output cmd_flags_t         q_flags,
    output logic [CNT_W-1:0]   q_count,
    output logic               ram_we,
    output logic [IDX_W:0]     ram_waddr,
    output logic [VALUE_W-1:0] ram_wdata
);

    localparam int KW = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);

    logic [CFG_W-1:0] group_size_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             wbank_reg;
    logic             wbank_next;
    logic [1:0]       busy_reg;
    logic [1:0]       busy_next;
    logic [CNT_W-1:0] k_eff;
    logic [KW-1:0]    size_wide;
    logic [CNT_W-1:0] n_new;
    logic             accept;
    logic             group_full;

    // zero acts as one, anything above MAX_GROUP is clipped
    always_comb
    begin
        size_wide = KW'(group_size_reg);
        if (group_size_reg == '0)
        begin
            k_eff = CNT_W'(1);
        end
        else if (size_wide > MAX_K)
        begin
            k_eff = CNT_W'(MAX_GROUP);
        end
        else
        begin
            k_eff = size_wide[CNT_W-1:0];
        end
    end

    assign s_tready   = !busy_reg[wbank_reg] && !q_full;
    assign accept     = s_tvalid && s_tready;
    assign n_new      = fill_reg + CNT_W'(1);
    assign group_full = (n_new >= k_eff);

    assign ram_we    = accept;
    assign ram_waddr = {wbank_reg, fill_reg[IDX_W-1:0]};
    assign ram_wdata = s_tdata;

    assign q_push          = accept && (group_full || s_tlast);
    assign q_flags.bank    = wbank_reg;
    assign q_flags.rev     = group_full;
    assign q_flags.seq_end = s_tlast;
    assign q_count         = n_new;

    always_comb
    begin
        fill_next  = fill_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (q_push)
            begin
                fill_next             = '0;
                wbank_next            = !wbank_reg;
                busy_next[wbank_reg]  = 1'b1;
            end
            else
            begin
                fill_next = n_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RST;
            fill_reg       <= '0;
            wbank_reg      <= 1'b0;
            busy_reg       <= 2'b00;
        end
        else
        begin
            if (cfg_wen)
            begin
                group_size_reg <= cfg_wdata;
            end
            fill_reg  <= fill_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ===== src/brkg_back.sv =====
// Back end: drains one bank per command, reversed or in order, into the output.
module brkg_back
    import brkg_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF,
    parameter int CNT_W     = $clog2(MAX_GROUP + 1),
    parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  cmd_flags_t       q_flags,
    input  logic [CNT_W-1:0] q_count,
    output logic             ram_re,
    output logic [IDX_W:0]   ram_raddr,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             m_tlast,   // run_last
    output logic             m_tuser,   // out_seq_end
    output bank_rel_t        rel
);

    back_state_t      state_reg;
    back_state_t      state_next;
    cmd_flags_t       flags_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    logic             last_reg;
    logic             end_reg;
    logic             slot_free;
    logic             issue;
    logic             is_last;
    logic [CNT_W-1:0] offset;

    assign slot_free = !valid_reg || m_tready;
    assign is_last   = (idx_reg == n_reg - CNT_W'(1));
    assign offset    = flags_reg.rev ? (n_reg - CNT_W'(1) - idx_reg) : idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (slot_free && is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            BK_RUN:
            begin
                issue = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (q_pop)
        begin
            idx_next = '0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (issue)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    assign ram_re    = issue;
    assign ram_raddr = {flags_reg.bank, offset[IDX_W-1:0]};

    // bank is free once its last word has been read into the output register
    assign rel.valid = issue && is_last;
    assign rel.bank  = flags_reg.bank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            flags_reg <= q_flags;
            n_reg     <= q_count;
        end
        if (issue)
        begin
            last_reg <= is_last;
            end_reg  <= is_last && flags_reg.seq_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = end_reg;

endmodule

// ===== src/block_reverse_k_group_top.sv =====
// The edge accepting a group's completing word stores it and queues the command; an idle
// back end then pops the command and reads the first word into the output register.
// Throughput: one input word per cycle while a bank is free and the queue has room;
// output one word per cycle within a group while not stalled, with the back end in
// idle between groups to fetch the next command. Two banks let the front fill one group
// while the back drains the other. Reset (async, active low) clears fill count, bank
// state, queue and output valid; group_size resets to 1. Stored words are not cleared.
module block_reverse_k_group_top
    import brkg_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [CFG_W-1:0]   cfg_wdata,  // group_size
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // value
    input  logic               s_tlast,    // seq_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,    // out_value
    output logic               m_tlast,    // run_last
    output logic               m_tuser     // out_seq_end
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CMD_W = FLAGS_W + CNT_W;

    bank_rel_t          rel;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    cmd_flags_t         push_flags;
    logic [CNT_W-1:0]   push_count;
    logic [CMD_W-1:0]   pop_data;
    cmd_flags_t         pop_flags;
    logic [CNT_W-1:0]   pop_count;
    logic               ram_we;
    logic [IDX_W:0]     ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W:0]     ram_raddr;

    assign pop_flags = pop_data[CMD_W-1:CNT_W];
    assign pop_count = pop_data[CNT_W-1:0];

    brkg_front #(
        .MAX_GROUP (MAX_GROUP),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .rel       (rel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_flags   (push_flags),
        .q_count   (push_count),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    brkg_cmdq #(
        .DATA_W (CMD_W)
    ) u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_flags, push_count}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    brkg_ram #(
        .ADDR_W (IDX_W + 1)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (m_tdata)
    );

    brkg_back #(
        .MAX_GROUP (MAX_GROUP),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_flags   (pop_flags),
        .q_count   (pop_count),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .rel       (rel)
    );

endmodule
